// ----- design/ulj_pkg.sv -----
// shared types and constants for the utility list join unit
// depends on nothing; used by every module of the block except ulj_ram
package ulj_pkg;

    // list storage sizing
    localparam int LIST_DEPTH = 64;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    // field widths
    localparam int TID_W   = 24;
    localparam int UTIL_W  = 32;
    localparam int ITEM_W  = 24;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 38;

    // operation codes of the request
    localparam logic [1:0] OP_LOAD_PREFIX = 2'd0;
    localparam logic [1:0] OP_LOAD_X      = 2'd1;
    localparam logic [1:0] OP_LOAD_Y      = 2'd2;
    localparam logic [1:0] OP_JOIN        = 2'd3;

    // input request
    typedef struct packed {
        logic [1:0]        operation;
        logic [TID_W-1:0]  tid;
        logic [UTIL_W-1:0] iutil;
        logic [UTIL_W-1:0] rutil;
        logic [ITEM_W-1:0] item;
    } t_in_item;

    // result request
    typedef struct packed {
        logic [ITEM_W-1:0]  item_id;
        logic [TID_W-1:0]   out_tid;
        logic [UTIL_W-1:0]  out_iutil;
        logic [UTIL_W-1:0]  out_rutil;
        logic               matched;
        logic [COUNT_W-1:0] entry_count;
        logic [SUM_W-1:0]   iutil_total;
        logic [SUM_W-1:0]   rutil_total;
        logic               last;
        logic               overflow;
    } t_out_item;

    // decoded command kinds
    typedef enum logic [3:0] {
        KIND_PREFIX = 4'b0001,
        KIND_X      = 4'b0010,
        KIND_Y      = 4'b0100,
        KIND_JOIN   = 4'b1000
    } t_kind;

    // command passed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [TID_W-1:0]  tid;
        logic [UTIL_W-1:0] iutil;
        logic [UTIL_W-1:0] rutil;
        logic [ITEM_W-1:0] item;
    } t_cmd;

    // list entries as stored
    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [UTIL_W-1:0] util;
    } t_pair_ent;

    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [UTIL_W-1:0] iutil;
        logic [UTIL_W-1:0] rutil;
    } t_y_ent;

    // ram widths of the stored entries
    localparam int PAIR_W = $bits(t_pair_ent);
    localparam int Y_W    = $bits(t_y_ent);

endpackage

// ----- design/ulj_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module ulj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/ulj_front.sv -----
// front end: accepts requests, decodes the operation and queues commands
// depends on ulj_pkg
module ulj_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ulj_pkg::t_in_item i_in,
    output logic              o_full,
    output logic              o_cmd_valid,
    output ulj_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);

    ulj_pkg::t_cmd r_q [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    ulj_pkg::t_cmd dec_cmd;
    logic          do_push;
    logic          do_pop;

    // classify the operation
    always_comb begin
        dec_cmd.tid   = i_in.tid;
        dec_cmd.iutil = i_in.iutil;
        dec_cmd.rutil = i_in.rutil;
        dec_cmd.item  = i_in.item;
        unique case (i_in.operation)
            ulj_pkg::OP_LOAD_PREFIX: dec_cmd.kind = ulj_pkg::KIND_PREFIX;
            ulj_pkg::OP_LOAD_X:      dec_cmd.kind = ulj_pkg::KIND_X;
            ulj_pkg::OP_LOAD_Y:      dec_cmd.kind = ulj_pkg::KIND_Y;
            default:                 dec_cmd.kind = ulj_pkg::KIND_JOIN;
        endcase
    end

    // two-entry command queue
    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

// ----- design/ulj_back.sv -----
// back end: holds the three lists, runs the merge walk and queues results
// depends on ulj_pkg and ulj_ram
module ulj_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  ulj_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_empty,
    output ulj_pkg::t_out_item o_out,
    input  logic               i_pop
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_CMP   = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [ulj_pkg::CNT_W-1:0] r_plen, n_plen, r_xlen, n_xlen, r_ylen, n_ylen;
    logic [ulj_pkg::CNT_W-1:0] r_ip, n_ip, r_ix, n_ix, r_iy, n_iy;
    logic                      r_dropped, n_dropped;
    logic [ulj_pkg::ITEM_W-1:0] r_item, n_item;
    logic [ulj_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [ulj_pkg::SUM_W-1:0] r_sum_i, n_sum_i, r_sum_r, n_sum_r;

    // matched entry waiting for its sums
    logic [ulj_pkg::TID_W-1:0]  r_m_tid, n_m_tid;
    logic [ulj_pkg::UTIL_W-1:0] r_m_iutil, n_m_iutil, r_m_rutil, n_m_rutil;

    // result held back until we know whether it is the last
    logic               r_pend_valid, n_pend_valid;
    ulj_pkg::t_out_item r_pend, n_pend;

    // output register
    logic               r_out_valid, n_out_valid;
    ulj_pkg::t_out_item r_out, n_out;

    ulj_pkg::t_pair_ent p_rd, x_rd;
    ulj_pkg::t_y_ent    y_rd;
    ulj_pkg::t_pair_ent pair_wdata;
    ulj_pkg::t_y_ent    y_wdata;
    logic               we_p, we_x, we_y;
    logic               out_space;
    logic               out_push;
    ulj_pkg::t_out_item out_data;
    logic [ulj_pkg::UTIL_W:0] util_sum;
    logic [ulj_pkg::UTIL_W:0] util_diff;
    logic [ulj_pkg::UTIL_W-1:0] putil;
    logic [ulj_pkg::UTIL_W-1:0] joined;

    // list memories
    assign pair_wdata.tid  = i_cmd.tid;
    assign pair_wdata.util = i_cmd.iutil;
    assign y_wdata.tid     = i_cmd.tid;
    assign y_wdata.iutil   = i_cmd.iutil;
    assign y_wdata.rutil   = i_cmd.rutil;

    always_comb begin
        we_p = 1'b0;
        we_x = 1'b0;
        we_y = 1'b0;
        if ((r_state == S_IDLE) && i_cmd_valid) begin
            we_p = (i_cmd.kind == ulj_pkg::KIND_PREFIX) && (r_plen < ulj_pkg::DEPTH_C);
            we_x = (i_cmd.kind == ulj_pkg::KIND_X) && (r_xlen < ulj_pkg::DEPTH_C);
            we_y = (i_cmd.kind == ulj_pkg::KIND_Y) && (r_ylen < ulj_pkg::DEPTH_C);
        end
    end

    ulj_ram #(.WIDTH(ulj_pkg::PAIR_W), .DEPTH(ulj_pkg::LIST_DEPTH)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (we_p),
        .i_waddr (r_plen[ulj_pkg::ADDR_W-1:0]),
        .i_wdata (pair_wdata),
        .i_raddr (r_ip[ulj_pkg::ADDR_W-1:0]),
        .o_rdata (p_rd)
    );

    ulj_ram #(.WIDTH(ulj_pkg::PAIR_W), .DEPTH(ulj_pkg::LIST_DEPTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (we_x),
        .i_waddr (r_xlen[ulj_pkg::ADDR_W-1:0]),
        .i_wdata (pair_wdata),
        .i_raddr (r_ix[ulj_pkg::ADDR_W-1:0]),
        .o_rdata (x_rd)
    );

    ulj_ram #(.WIDTH(ulj_pkg::Y_W), .DEPTH(ulj_pkg::LIST_DEPTH)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (we_y),
        .i_waddr (r_ylen[ulj_pkg::ADDR_W-1:0]),
        .i_wdata (y_wdata),
        .i_raddr (r_iy[ulj_pkg::ADDR_W-1:0]),
        .o_rdata (y_rd)
    );

    // joined utility: x + y - prefix, clamped at zero and saturated
    always_comb begin
        putil = '0;
        if ((r_ip < r_plen) && (p_rd.tid == x_rd.tid)) begin
            putil = p_rd.util;
        end
        util_sum  = {1'b0, x_rd.util} + {1'b0, y_rd.iutil};
        util_diff = util_sum - {1'b0, putil};
        if (util_sum < {1'b0, putil}) begin
            joined = '0;
        end else if (util_diff[ulj_pkg::UTIL_W]) begin
            joined = '1;
        end else begin
            joined = util_diff[ulj_pkg::UTIL_W-1:0];
        end
    end

    assign out_space = !r_out_valid || i_pop;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_plen       = r_plen;
        n_xlen       = r_xlen;
        n_ylen       = r_ylen;
        n_ip         = r_ip;
        n_ix         = r_ix;
        n_iy         = r_iy;
        n_dropped    = r_dropped;
        n_item       = r_item;
        n_cnt        = r_cnt;
        n_sum_i      = r_sum_i;
        n_sum_r      = r_sum_r;
        n_m_tid      = r_m_tid;
        n_m_iutil    = r_m_iutil;
        n_m_rutil    = r_m_rutil;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_cmd_take   = 1'b0;
        out_push     = 1'b0;
        out_data     = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.kind)
                        ulj_pkg::KIND_PREFIX: begin
                            if (we_p) n_plen = r_plen + 1'b1;
                            else      n_dropped = 1'b1;
                        end
                        ulj_pkg::KIND_X: begin
                            if (we_x) n_xlen = r_xlen + 1'b1;
                            else      n_dropped = 1'b1;
                        end
                        ulj_pkg::KIND_Y: begin
                            if (we_y) n_ylen = r_ylen + 1'b1;
                            else      n_dropped = 1'b1;
                        end
                        default: begin
                            n_item       = i_cmd.item;
                            n_ip         = '0;
                            n_ix         = '0;
                            n_iy         = '0;
                            n_cnt        = '0;
                            n_sum_i      = '0;
                            n_sum_r      = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_FETCH;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // read addresses are the pointers; data comes next cycle
                if ((r_ix < r_xlen) && (r_iy < r_ylen)) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_CMP: begin
                priority if (x_rd.tid < y_rd.tid) begin
                    n_ix    = r_ix + 1'b1;
                    n_state = S_FETCH;
                end else if (x_rd.tid > y_rd.tid) begin
                    n_iy    = r_iy + 1'b1;
                    n_state = S_FETCH;
                end else if ((r_ip < r_plen) && (p_rd.tid < x_rd.tid)) begin
                    // prefix pointer catches up one entry at a time
                    n_ip    = r_ip + 1'b1;
                    n_state = S_FETCH;
                end else begin
                    n_m_tid   = x_rd.tid;
                    n_m_iutil = joined;
                    n_m_rutil = y_rd.rutil;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_pend_valid || out_space) begin
                    out_push          = r_pend_valid;
                    out_data          = r_pend;
                    out_data.last     = 1'b0;
                    n_cnt             = r_cnt + 1'b1;
                    n_sum_i           = r_sum_i + ulj_pkg::SUM_W'(r_m_iutil);
                    n_sum_r           = r_sum_r + ulj_pkg::SUM_W'(r_m_rutil);
                    n_pend_valid      = 1'b1;
                    n_pend.item_id    = r_item;
                    n_pend.out_tid    = r_m_tid;
                    n_pend.out_iutil  = r_m_iutil;
                    n_pend.out_rutil  = r_m_rutil;
                    n_pend.matched    = 1'b1;
                    n_pend.entry_count = n_cnt;
                    n_pend.iutil_total = n_sum_i;
                    n_pend.rutil_total = n_sum_r;
                    n_pend.last       = 1'b0;
                    n_pend.overflow   = r_dropped;
                    n_ix              = r_ix + 1'b1;
                    n_iy              = r_iy + 1'b1;
                    n_state           = S_FETCH;
                end
            end
            S_FLUSH: begin
                if (out_space) begin
                    out_push = 1'b1;
                    if (r_pend_valid) begin
                        out_data      = r_pend;
                        out_data.last = 1'b1;
                    end else begin
                        // empty join gives one unmatched result
                        out_data          = '0;
                        out_data.item_id  = r_item;
                        out_data.last     = 1'b1;
                        out_data.overflow = r_dropped;
                    end
                    n_pend_valid = 1'b0;
                    n_plen       = '0;
                    n_xlen       = '0;
                    n_ylen       = '0;
                    n_dropped    = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_push) begin
            n_out_valid = 1'b1;
            n_out       = out_data;
        end else if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_plen       <= '0;
            r_xlen       <= '0;
            r_ylen       <= '0;
            r_dropped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_plen       <= n_plen;
            r_xlen       <= n_xlen;
            r_ylen       <= n_ylen;
            r_dropped    <= n_dropped;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        r_ip      <= n_ip;
        r_ix      <= n_ix;
        r_iy      <= n_iy;
        r_item    <= n_item;
        r_cnt     <= n_cnt;
        r_sum_i   <= n_sum_i;
        r_sum_r   <= n_sum_r;
        r_m_tid   <= n_m_tid;
        r_m_iutil <= n_m_iutil;
        r_m_rutil <= n_m_rutil;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

endmodule

// ----- design/utility_list_join_unit.sv -----
// utility list join unit: a load is taken from the head of the queue when idle.
// a join walks x and y in steps of a ram read (fetch) and a compare, one more
// step per prefix entry skipped and an emit state per common tid; results
// leave through a single output register that takes one only when empty or popped.
// reset clears list lengths, overflow flag and queues; list rams are not cleared.
// depends on ulj_pkg, ulj_front, ulj_back, ulj_ram
module utility_list_join_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ulj_pkg::t_in_item  i_in,
    output logic               o_full,
    output logic               o_empty,
    output ulj_pkg::t_out_item o_out,
    input  logic               i_pop
);

    logic          cmd_valid;
    logic          cmd_take;
    ulj_pkg::t_cmd cmd;

    // request intake and decode
    ulj_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // list storage and merge engine
    ulj_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (o_empty),
        .o_out       (o_out),
        .i_pop       (i_pop)
    );

endmodule
